// File: hdl/capture_ring_batch_tracker_assert.svh
// Assertion macros for the capture ring batch tracker.
// Used by the top level; depends on nothing else.
`ifndef CAPTURE_RING_BATCH_TRACKER_ASSERT_SVH
`define CAPTURE_RING_BATCH_TRACKER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define CRBT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("capture ring batch tracker: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define CRBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("capture ring batch tracker: next-cycle check failed");

`endif

// File: hdl/crbt_pkg.sv
// Shared types and constants for the capture ring batch tracker.
// Used by the controller, the datapath and the top level.
package crbt_pkg;

  // Field widths of the request and result items.
  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned RI_W      = 11;
  localparam int unsigned SIZE_W    = 10;
  localparam int unsigned MASK_W    = 5;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned ALIGN_LSB = 6;

  // Round-robin mask reported for the dual-input mode.
  localparam logic [MASK_W-1:0] RR_MASK_BOTH = 5'd3;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_START    = 2'd0,
    REQ_BATCH    = 2'd1,
    REQ_COMPLETE = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_type_e;

  // Channel mode codes of a start request.
  typedef enum logic [1:0] {
    MODE_INVALID     = 2'd0,
    MODE_INPUT0      = 2'd1,
    MODE_INPUT1      = 2'd2,
    MODE_ROUND_ROBIN = 2'd3
  } chan_mode_e;

  // Occupancy of the result register.
  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } out_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
  } crbt_cmd_t;

endpackage

// File: hdl/capture_ring_batch_tracker.sv
// Top level of the capture ring batch tracker.
// Depends on crbt_pkg, crbt_ctrl, crbt_datapath and the assertion header.

// Every request item yields exactly one result item, registered and shown
// in the cycle after the item is accepted. The block takes one item per cycle:
// a single result register sits between the two sides, and the input is
// stalled only while that register holds a result that the output side is
// stalling. All ring arithmetic for an item (address fold, batch size, read
// index advance, re-arm compare) completes in the cycle it is accepted.
`include "capture_ring_batch_tracker_assert.svh"

module capture_ring_batch_tracker import crbt_pkg::*; #(
  parameter int BUFFER_BYTES = 2048,
  parameter int MAX_BATCH    = 960
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [ADDR_W-1:0] write_address_i,
  input  logic [1:0]        channel_mode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ADDR_W-1:0] batch_offset_o,
  output logic [SIZE_W-1:0] batch_size_o,
  output logic              dma_rearm_o,
  output logic              capture_stopped_o,
  output logic              capture_started_o,
  output logic              input_select_o,
  output logic [MASK_W-1:0] round_robin_mask_o
);

  // Batch cap one bit wider than the size field, so a cap of 1024 still fits.
  localparam logic [SIZE_W:0] MaxBatchExt = (SIZE_W + 1)'(MAX_BATCH);

  crbt_cmd_t cmd;

  // Handshake controller.
  crbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Ring state and result register.
  crbt_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_BATCH    (MAX_BATCH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .req_type_i         (req_type_i),
    .write_address_i    (write_address_i),
    .channel_mode_i     (channel_mode_i),
    .batch_offset_o     (batch_offset_o),
    .batch_size_o       (batch_size_o),
    .dma_rearm_o        (dma_rearm_o),
    .capture_stopped_o  (capture_stopped_o),
    .capture_started_o  (capture_started_o),
    .input_select_o     (input_select_o),
    .round_robin_mask_o (round_robin_mask_o)
  );

  // The input side only stalls behind a pending result.
  `CRBT_ASSERT_IMPL(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_o)
  // An accepted item always produces a result in the next cycle.
  `CRBT_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)
  // A buffer-complete answer never both re-arms and stops.
  `CRBT_ASSERT_IMPL(a_rearm_xor_stop, clk_i, rst_ni, out_valid_o, !(dma_rearm_o && capture_stopped_o))
  // A batch never exceeds the configured cap.
  `CRBT_ASSERT_IMPL(a_batch_capped, clk_i, rst_ni, out_valid_o, {1'b0, batch_size_o} <= MaxBatchExt)

endmodule

// File: hdl/crbt_ctrl.sv
// Handshake controller of the capture ring batch tracker.
// Depends on crbt_pkg; tracks whether the result register holds an item.
module crbt_ctrl import crbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output crbt_cmd_t cmd_o
);

  out_state_e state_q, state_d;
  logic       accept;

  // A new item enters whenever the result register is free or being emptied.
  assign accept = in_valid_i && !in_stall_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (accept) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (!out_stall_i && !accept) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_EMPTY: begin
        in_stall_o  = 1'b0;
        out_valid_o = 1'b0;
      end
      ST_FULL: begin
        in_stall_o  = out_stall_i;
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b0;
      end
    endcase
    cmd_o.load = in_valid_i && !in_stall_o;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/crbt_datapath.sv
// Datapath of the capture ring batch tracker: ring state and result register.
// Depends on crbt_pkg; driven by the load command of crbt_ctrl.
module crbt_datapath import crbt_pkg::*; #(
  parameter int BUFFER_BYTES = 2048,
  parameter int MAX_BATCH    = 960
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crbt_cmd_t         cmd_i,
  input  logic [1:0]        req_type_i,
  input  logic [ADDR_W-1:0] write_address_i,
  input  logic [1:0]        channel_mode_i,
  output logic [ADDR_W-1:0] batch_offset_o,
  output logic [SIZE_W-1:0] batch_size_o,
  output logic              dma_rearm_o,
  output logic              capture_stopped_o,
  output logic              capture_started_o,
  output logic              input_select_o,
  output logic [MASK_W-1:0] round_robin_mask_o
);

  localparam logic [ADDR_W-1:0] BufBytes = ADDR_W'(BUFFER_BYTES);
  localparam logic [ADDR_W-1:0] MaxBatch = ADDR_W'(MAX_BATCH);

  // The fill and drain counts only matter through their difference, so the
  // datapath keeps fill_count - drain_count, which wraps the same way.
  logic [RI_W-1:0]    read_index_q, read_index_d;
  logic [COUNT_W-1:0] fill_ahead_q, fill_ahead_d;

  logic [ADDR_W-1:0]  cur;
  logic [ADDR_W-1:0]  ri_ext;
  logic [ADDR_W-1:0]  fwd;
  logic [ADDR_W-1:0]  rem;
  logic [ADDR_W-1:0]  size;
  logic [ADDR_W-1:0]  ri_next;
  logic [COUNT_W-1:0] ahead_inc;
  logic               below_two;
  logic               rearm;

  logic [ADDR_W-1:0]  offset_d;
  logic [SIZE_W-1:0]  size_d;
  logic               rearm_d, stopped_d, started_d, select_d;
  logic [MASK_W-1:0]  mask_d;

  // Align the write address down to 64 bytes and fold it into the buffer.
  always_comb begin
    cur = {write_address_i[ADDR_W-1:ALIGN_LSB], ALIGN_LSB'(0)};
    for (int i = 0; i < 3; i++) begin
      if (cur >= BufBytes) cur = cur - BufBytes;
    end
  end

  // Batch size and read index advance.
  always_comb begin
    ri_ext  = {1'b0, read_index_q};
    fwd     = cur - ri_ext;
    rem     = BufBytes - ri_ext;
    size    = fwd;
    ri_next = ri_ext;
    if (cur >= ri_ext) begin
      size    = (fwd > MaxBatch) ? MaxBatch : fwd;
      ri_next = ri_ext + size;
    end else if (rem > MaxBatch) begin
      size    = MaxBatch;
      ri_next = ri_ext + MaxBatch;
    end else begin
      size    = rem;
      ri_next = '0;
    end
  end

  // Re-arm decision on a buffer-complete request.
  always_comb begin
    ahead_inc = fill_ahead_q + COUNT_W'(1);
    below_two = (ahead_inc < COUNT_W'(2)) || ahead_inc[COUNT_W-1];
    rearm     = (below_two && (read_index_q != '0)) || (ahead_inc == '0);
  end

  // Request decoder: next state and result fields.
  always_comb begin
    read_index_d = read_index_q;
    fill_ahead_d = fill_ahead_q;
    offset_d     = '0;
    size_d       = '0;
    rearm_d      = 1'b0;
    stopped_d    = 1'b0;
    started_d    = 1'b0;
    select_d     = 1'b0;
    mask_d       = '0;
    unique case (req_type_e'(req_type_i))
      REQ_START: begin
        read_index_d = '0;
        fill_ahead_d = '0;
        unique case (chan_mode_e'(channel_mode_i))
          MODE_INPUT0: started_d = 1'b1;
          MODE_INPUT1: begin
            started_d = 1'b1;
            select_d  = 1'b1;
          end
          MODE_ROUND_ROBIN: begin
            started_d = 1'b1;
            mask_d    = RR_MASK_BOTH;
          end
          default: started_d = 1'b0;
        endcase
      end
      REQ_BATCH: begin
        offset_d     = {1'b1, read_index_q};
        size_d       = size[SIZE_W-1:0];
        read_index_d = ri_next[RI_W-1:0];
        if ((cur < ri_ext) && (rem <= MaxBatch)) begin
          fill_ahead_d = fill_ahead_q - COUNT_W'(1);
        end
      end
      REQ_COMPLETE: begin
        fill_ahead_d = ahead_inc;
        rearm_d      = rearm;
        stopped_d    = !rearm;
      end
      default: ;
    endcase
  end

  // Ring state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_index_q <= '0;
      fill_ahead_q <= '0;
    end else if (cmd_i.load) begin
      read_index_q <= read_index_d;
      fill_ahead_q <= fill_ahead_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      batch_offset_o     <= offset_d;
      batch_size_o       <= size_d;
      dma_rearm_o        <= rearm_d;
      capture_stopped_o  <= stopped_d;
      capture_started_o  <= started_d;
      input_select_o     <= select_d;
      round_robin_mask_o <= mask_d;
    end
  end

endmodule
